@@ rtl/pdnfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pdnfs_pkg: shared types and name tables
// Name strings, lengths and flag mapping for the PDF dictionary name scanner,
// plus the per-transfer control struct used by the cell row and accumulator.
// ----------------------------------------------------------------------------
package pdnfs_pkg;

	// Longest name in the table sets the number of cells in the row.
	localparam int WIN_LEN    = 16;
	localparam int RULE_COUNT = 24;
	localparam int OBJ_BITS   = 10;
	localparam int FLT_BITS   = 10;

	typedef logic [RULE_COUNT-1:0] rule_vec_t;

	// Flag group that a matched name feeds.
	typedef enum logic [1:0] {
		GRP_OBJ = 2'd0,
		GRP_FLT = 2'd1,
		GRP_KEY = 2'd2
	} grp_t;

	// Control for one input transfer, shared by all cells and the accumulator.
	typedef struct packed {
		logic take;
		logic last;
	} step_t;

	// Name text, right-justified: the final character sits in bits 7:0.
	localparam logic [127:0] RULE_TEXT [RULE_COUNT] = '{
		"/JavaScript",
		"/JS",
		"/OpenAction",
		"/AA",
		"/Launch",
		"/EmbeddedFile",
		"/Filespec",
		"/ObjStm",
		"/URI",
		"/GoToE",
		"/RichMedia",
		"/XFA",
		"/AcroForm",
		"/FlateDecode",
		"/LZWDecode",
		"/ASCIIHexDecode",
		"/ASCII85Decode",
		"/RunLengthDecode",
		"/DCTDecode",
		"/CCITTFaxDecode",
		"/JBIG2Decode",
		"/JPXDecode",
		"/Crypt",
		"/Filter"
	};

	localparam logic [4:0] RULE_LEN [RULE_COUNT] = '{
		5'd11, 5'd3, 5'd11, 5'd3, 5'd7, 5'd13, 5'd9, 5'd7, 5'd4, 5'd6,
		5'd10, 5'd4, 5'd9, 5'd12, 5'd10, 5'd15, 5'd14, 5'd16, 5'd10, 5'd15,
		5'd12, 5'd10, 5'd6, 5'd7
	};

	localparam grp_t RULE_GRP [RULE_COUNT] = '{
		GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ,
		GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ, GRP_OBJ,
		GRP_FLT, GRP_FLT, GRP_FLT, GRP_FLT, GRP_FLT, GRP_FLT, GRP_FLT, GRP_FLT,
		GRP_FLT, GRP_FLT,
		GRP_KEY
	};

	localparam logic [3:0] RULE_BIT [RULE_COUNT] = '{
		4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd5, 4'd6,
		4'd7, 4'd8, 4'd9,
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
		4'd0
	};

	// Character k (counted from the leading slash) of name r; zero past the end.
	function automatic logic [7:0] rule_char(int r, int k);
		logic [7:0] ch;
		ch = 8'h00;
		if (k < int'(RULE_LEN[r])) begin
			ch = RULE_TEXT[r][(int'(RULE_LEN[r]) - 1 - k)*8 +: 8];
		end
		return ch;
	endfunction

endpackage

@@ rtl/pdf_dict_name_flag_scan.sv @@
// The result appears in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle; the cell row and the compares are all parallel.
// A last byte waits only while the previous result is still held and not taken.
// Reset (arst_n low) clears the cell row, the flag accumulators and the result
// valid; the block accepts bytes in the first cycle after reset is released.
// ----------------------------------------------------------------------------
// pdf_dict_name_flag_scan: PDF dictionary name flag scanner
// Streams the bytes of one dictionary through a row of sixteen match cells,
// one per character position, and reports object, filter and anomaly flags
// at the end of each dictionary.
// ----------------------------------------------------------------------------
module pdf_dict_name_flag_scan
	import pdnfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [9:0]  object_flags,
	output logic [10:0] filter_flags,
	output logic [5:0]  anomaly_flags
);

	step_t     step;
	rule_vec_t chain [WIN_LEN+1];
	rule_vec_t cell_hit [WIN_LEN];
	rule_vec_t hits;

	// Only a last byte has to wait for room in the result register.
	assign item_ready = !result_valid || result_ready || !last_byte;
	assign step.take  = item_valid && item_ready;
	assign step.last  = last_byte;

	// Row of match cells; the first one sees every name as a live prefix.
	assign chain[0] = '1;

	for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
		pdnfs_cell #(
			.K(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.data_byte (data_byte),
			.prev      (chain[g]),
			.state     (chain[g+1]),
			.hit       (cell_hit[g])
		);
	end

	// Combine the hits of all cells.
	always_comb begin
		hits = '0;
		for (int k = 0; k < WIN_LEN; k++) begin
			hits = hits | cell_hit[k];
		end
	end

	pdnfs_flag_acc u_flag_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.hits          (hits),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.object_flags  (object_flags),
		.filter_flags  (filter_flags),
		.anomaly_flags (anomaly_flags)
	);

	// No name is longer than the row, so the final cell never keeps a prefix.
	a_row_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		chain[WIN_LEN] == '0)
		else $error("prefix state past the final cell");

	// A dictionary end leaves no prefix alive for the next dictionary.
	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step.take && step.last |=> chain[1] == '0 && chain[2] == '0)
		else $error("prefix state survived a dictionary end");

	// A last-byte transfer always produces a held result.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		step.take && step.last |=> result_valid)
		else $error("result missing after last byte");

	// Anomaly bits mirror the low five object flags and the unknown-filter bit.
	a_anomaly_copy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> anomaly_flags[4:0] == object_flags[4:0]
			&& anomaly_flags[5] == filter_flags[10])
		else $error("anomaly flags disagree with object or filter flags");

	// Unknown filter only when no known filter name was found.
	a_unknown_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && filter_flags[10] |-> filter_flags[9:0] == '0)
		else $error("unknown filter set together with a known filter");

endmodule

@@ rtl/pdnfs_cell.sv @@
// ----------------------------------------------------------------------------
// pdnfs_cell: one character position of the name matcher
// Cell K checks the current byte against character K of every name. It keeps
// the unfinished names whose first K+1 characters matched and hands that vector
// to cell K+1. A name whose last character is K reports a hit here.
// ----------------------------------------------------------------------------
module pdnfs_cell
	import pdnfs_pkg::*;
#(
	parameter int K = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  step_t     step,
	input  logic [7:0] data_byte,
	input  rule_vec_t prev,
	output rule_vec_t state,
	output rule_vec_t hit
);

	rule_vec_t cmp;
	rule_vec_t keep;
	rule_vec_t state_q;

	// Extend every live prefix by the current byte.
	always_comb begin
		for (int r = 0; r < RULE_COUNT; r++) begin
			cmp[r]  = prev[r] && (K < int'(RULE_LEN[r])) && (data_byte == rule_char(r, K));
			hit[r]  = cmp[r] && (K == int'(RULE_LEN[r]) - 1);
			keep[r] = cmp[r] && (K < int'(RULE_LEN[r]) - 1);
		end
	end

	// Prefix state advances on each transfer and is dropped at dictionary end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step.take) begin
			state_q <= step.last ? '0 : keep;
		end
	end

	assign state = state_q;

endmodule

@@ rtl/pdnfs_flag_acc.sv @@
// ----------------------------------------------------------------------------
// pdnfs_flag_acc: flag accumulator and result register
// Folds the name hits into object, filter and key flags over one dictionary
// and loads the finished flags into the result register on the last byte.
// ----------------------------------------------------------------------------
module pdnfs_flag_acc
	import pdnfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  step_t       step,
	input  rule_vec_t   hits,
	input  logic        result_ready,
	output logic        result_valid,
	output logic [9:0]  object_flags,
	output logic [10:0] filter_flags,
	output logic [5:0]  anomaly_flags
);

	logic [OBJ_BITS-1:0] obj_hit;
	logic [FLT_BITS-1:0] flt_hit;
	logic                key_hit;
	logic [OBJ_BITS-1:0] obj_next;
	logic [FLT_BITS-1:0] flt_next;
	logic                key_next;
	logic                unknown;

	logic [OBJ_BITS-1:0] obj_acc_q;
	logic [FLT_BITS-1:0] flt_acc_q;
	logic                key_seen_q;
	logic                valid_q;
	logic [9:0]          object_q;
	logic [10:0]         filter_q;
	logic [5:0]          anomaly_q;

	// Map each name hit onto its flag group and bit.
	always_comb begin
		obj_hit = '0;
		flt_hit = '0;
		key_hit = 1'b0;
		for (int r = 0; r < RULE_COUNT; r++) begin
			case (RULE_GRP[r])
				GRP_OBJ: obj_hit[RULE_BIT[r]] = obj_hit[RULE_BIT[r]] | hits[r];
				GRP_FLT: flt_hit[RULE_BIT[r]] = flt_hit[RULE_BIT[r]] | hits[r];
				GRP_KEY: key_hit = key_hit | hits[r];
				default: key_hit = key_hit;
			endcase
		end
	end

	// Flags including the byte now being transferred.
	assign obj_next = obj_acc_q | obj_hit;
	assign flt_next = flt_acc_q | flt_hit;
	assign key_next = key_seen_q | key_hit;
	assign unknown  = key_next && (flt_next == '0);

	// Accumulators clear after the last byte of a dictionary.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_acc_q  <= '0;
			flt_acc_q  <= '0;
			key_seen_q <= 1'b0;
		end else if (step.take) begin
			if (step.last) begin
				obj_acc_q  <= '0;
				flt_acc_q  <= '0;
				key_seen_q <= 1'b0;
			end else begin
				obj_acc_q  <= obj_next;
				flt_acc_q  <= flt_next;
				key_seen_q <= key_next;
			end
		end
	end

	// Result register: filled on the last byte, emptied by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step.take && step.last) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.take && step.last) begin
			object_q  <= obj_next;
			filter_q  <= {unknown, flt_next};
			anomaly_q <= {unknown, obj_next[4:0]};
		end
	end

	assign result_valid  = valid_q;
	assign object_flags  = object_q;
	assign filter_flags  = filter_q;
	assign anomaly_flags = anomaly_q;

endmodule
